// File: hdl/rcfp_pkg.sv
// Shared types and constants of the RC frame parser and scaler.
`timescale 1ns / 1ps
package rcfp_pkg;

	// Configuration port
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 8;
	localparam logic [CfgIdxW-1:0] CfgStartMarker = 1'b0;
	localparam logic [CfgIdxW-1:0] CfgEndMarker   = 1'b1;

	localparam logic [7:0] StartMarkerRst = 8'h66;
	localparam logic [7:0] EndMarkerRst   = 8'h99;

	localparam logic [2:0] PayloadLen = 3'd5;

	localparam int QueueDepth = 2;

	// roll/pitch: floor((RpOffset + b*RpGain) / 96), done as >>5 then /3
	localparam logic [17:0] RpOffset = 18'd64000;
	localparam logic [9:0]  RpGain   = 10'd625;
	localparam logic [15:0] RpRecip3 = 16'd43691;  // ceil(2^17 / 3)
	// yaw: floor((YawOffset + b*YawGain) / 203)
	localparam logic [18:0] YawOffset = 19'd202100;
	localparam logic [9:0]  YawGain   = 10'd800;
	localparam logic [19:0] YawRecip  = 20'd661172; // ceil(2^27 / 203)
	// thrust: 1000 + floor(b*256000 / 65535)
	localparam logic [17:0] ThrGain   = 18'd256000;
	localparam logic [16:0] ThrDiv    = 17'd65535;
	localparam logic [10:0] ThrOffset = 11'd1000;

	typedef struct packed {
		logic [7:0] roll;
		logic [7:0] pitch;
		logic [7:0] thrust;
		logic [7:0] yaw;
	} raw_frame_t;

endpackage

// File: hdl/rcfp_if.sv
// Handshake channels: received bytes in, scaled servo commands out.
`timescale 1ns / 1ps
interface rcfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfp_servo_if;
	logic        valid;
	logic        ready;
	logic [11:0] roll_us;
	logic [11:0] pitch_us;
	logic [10:0] yaw_us;
	logic [10:0] thrust_us;

	modport source (output valid, output roll_us, output pitch_us, output yaw_us,
		output thrust_us, input ready);
	modport sink (input valid, input roll_us, input pitch_us, input yaw_us,
		input thrust_us, output ready);
endinterface

// File: hdl/rcfp_front.sv
// Byte-level frame parser: markers, payload capture, XOR checksum.
`timescale 1ns / 1ps
module rcfp_front (
	input  logic                           clk,
	input  logic                           arst_n,
	rcfp_byte_if.sink                      rx,
	input  logic                           cfg_wr_en,
	input  logic [rcfp_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rcfp_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic                           q_full,
	output logic                           push,
	output rcfp_pkg::raw_frame_t           push_data
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_DATA,
		PH_CHK,
		PH_END
	} phase_t;

	phase_t     phase_q;
	logic [2:0] pos_q;
	logic [7:0] xor_q;
	logic [7:0] store_q [4];
	logic [7:0] start_q;
	logic [7:0] end_q;
	logic       xfer;

	// Only the end byte needs room in the queue
	assign rx.ready = (phase_q != PH_END) || !q_full;
	assign xfer     = rx.valid && rx.ready;
	assign push     = xfer && (phase_q == PH_END) && (rx.rx_byte == end_q);

	assign push_data.roll   = store_q[0];
	assign push_data.pitch  = store_q[1];
	assign push_data.thrust = store_q[2];
	assign push_data.yaw    = store_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= rcfp_pkg::StartMarkerRst;
			end_q   <= rcfp_pkg::EndMarkerRst;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				rcfp_pkg::CfgStartMarker: start_q <= cfg_wdata;
				rcfp_pkg::CfgEndMarker:   end_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= 3'd0;
			xor_q   <= 8'd0;
		end else if (xfer) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx.rx_byte == start_q) begin
						pos_q   <= 3'd0;
						xor_q   <= 8'd0;
						phase_q <= PH_DATA;
					end
				end
				PH_DATA: begin
					xor_q <= xor_q ^ rx.rx_byte;
					pos_q <= pos_q + 3'd1;
					if (pos_q >= rcfp_pkg::PayloadLen - 3'd1) begin
						phase_q <= PH_CHK;
					end
				end
				PH_CHK: begin
					phase_q <= (rx.rx_byte == xor_q) ? PH_END : PH_HUNT;
				end
				PH_END: begin
					phase_q <= PH_HUNT;
				end
				default: phase_q <= PH_HUNT;
			endcase
		end
	end

	// Capture roll, pitch, thrust, yaw; the command byte only feeds the checksum
	always_ff @(posedge clk) begin
		if (xfer && (phase_q == PH_DATA) && !pos_q[2]) begin
			store_q[pos_q[1:0]] <= rx.rx_byte;
		end
	end

endmodule

// File: hdl/rcfp_queue.sv
// Small register queue of checked frames between parser and scaler.
`timescale 1ns / 1ps
module rcfp_queue #(
	parameter int DEPTH = rcfp_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rcfp_pkg::raw_frame_t push_data,
	output logic                 full,
	input  logic                 pop,
	output rcfp_pkg::raw_frame_t head,
	output logic                 empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	rcfp_pkg::raw_frame_t entry_q [DEPTH];
	logic [PtrW-1:0]      wr_ptr_q;
	logic [PtrW-1:0]      rd_ptr_q;
	logic [CntW-1:0]      cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == FullCnt);
	assign empty   = (cnt_q == '0);
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hdl/rcfp_back.sv
// Scaling pipeline: raw payload bytes to pulse-width commands.
`timescale 1ns / 1ps
module rcfp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  rcfp_pkg::raw_frame_t q_head,
	output logic                 pop,
	rcfp_servo_if.source         servo
);

	// Stage 1: affine numerators
	logic        v_s1;
	logic [17:0] roll_s1;
	logic [17:0] pitch_s1;
	logic [18:0] yaw_s1;
	logic [25:0] thr_s1;
	// Stage 2: reciprocal products, thrust finished
	logic        v_s2;
	logic [28:0] roll_s2;
	logic [28:0] pitch_s2;
	logic [37:0] yaw_s2;
	logic [10:0] thr_s2;
	// Output register
	logic        out_v_q;
	logic [11:0] roll_q;
	logic [11:0] pitch_q;
	logic [10:0] yaw_q;
	logic [10:0] thr_q;

	logic        advance;
	logic [9:0]  thr_quo;
	logic [16:0] thr_rem;
	logic [9:0]  thr_fix;

	// Whole pipeline moves together; output register is the last stage
	assign advance = !out_v_q || servo.ready;
	assign pop     = advance && !q_empty;

	// floor(y/65535) from y>>16 plus one compare-and-correct
	assign thr_quo = thr_s1[25:16];
	assign thr_rem = {1'b0, thr_s1[15:0]} + {7'd0, thr_quo};
	assign thr_fix = (thr_rem >= rcfp_pkg::ThrDiv) ? thr_quo + 10'd1 : thr_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (advance) begin
			v_s1    <= !q_empty;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			roll_s1  <= rcfp_pkg::RpOffset + 18'(q_head.roll * rcfp_pkg::RpGain);
			pitch_s1 <= rcfp_pkg::RpOffset + 18'(q_head.pitch * rcfp_pkg::RpGain);
			yaw_s1   <= rcfp_pkg::YawOffset + 19'(q_head.yaw * rcfp_pkg::YawGain);
			thr_s1   <= 26'(q_head.thrust * rcfp_pkg::ThrGain);

			roll_s2  <= 29'(roll_s1[17:5] * rcfp_pkg::RpRecip3);
			pitch_s2 <= 29'(pitch_s1[17:5] * rcfp_pkg::RpRecip3);
			yaw_s2   <= 38'(yaw_s1 * rcfp_pkg::YawRecip);
			thr_s2   <= rcfp_pkg::ThrOffset + {1'b0, thr_fix};

			roll_q   <= roll_s2[28:17];
			pitch_q  <= pitch_s2[28:17];
			yaw_q    <= yaw_s2[37:27];
			thr_q    <= thr_s2;
		end
	end

	assign servo.valid     = out_v_q;
	assign servo.roll_us   = roll_q;
	assign servo.pitch_us  = pitch_q;
	assign servo.yaw_us    = yaw_q;
	assign servo.thrust_us = thr_q;

endmodule

// File: hdl/rc_frame_parser_scaler_unit.sv
// Top level of the RC frame parser and scaler.
//
//  port    | dir | carries                                   | transfer when
//  rx      | in  | rx_byte, one serial byte                  | rx.valid && rx.ready
//  servo   | out | roll_us, pitch_us, yaw_us, thrust_us      | servo.valid && servo.ready
//  cfg_*   | in  | cfg_index 0 start marker, 1 end marker    | cfg_wr_en
//
// One byte is taken per cycle while rx.ready is high. A good frame shows on servo
// after its end byte passes the queue, two scaling stages and output register.
// Reset clears the parser to hunting, the queue to empty and the markers to 0x66/0x99.
// A stalled servo side holds the scaling pipeline; the frame queue (QUEUE_DEPTH
// entries) absorbs further frames, and rx.ready drops only on an end byte with
// the queue full.
`timescale 1ns / 1ps
module rc_frame_parser_scaler_unit #(
	parameter int QUEUE_DEPTH = rcfp_pkg::QueueDepth
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rcfp_byte_if.sink                      rx,
	rcfp_servo_if.source                   servo,
	input  logic                           cfg_wr_en,
	input  logic [rcfp_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rcfp_pkg::CfgDataW-1:0]  cfg_wdata
);

	logic                 push;
	logic                 pop;
	logic                 q_full;
	logic                 q_empty;
	rcfp_pkg::raw_frame_t push_data;
	rcfp_pkg::raw_frame_t q_head;

	rcfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	rcfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	rcfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.pop     (pop),
		.servo   (servo)
	);

endmodule

// File: hdl/rcfp_checker.sv
// Port-level checks of the RC frame parser and scaler, bound to the top level.
`timescale 1ns / 1ps
module rcfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] roll_us,
	input logic [11:0] pitch_us,
	input logic [10:0] yaw_us,
	input logic [10:0] thrust_us
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(roll_us) && $stable(pitch_us)
			&& $stable(yaw_us) && $stable(thrust_us))
		else $error("servo payload changed while stalled");

	// Input backpressure only follows an output stall
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("rx.ready low without a servo stall");

	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> roll_us >= 12'd666 && roll_us <= 12'd2326
			&& pitch_us >= 12'd666 && pitch_us <= 12'd2326)
		else $error("roll/pitch out of range");

	a_yt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> yaw_us >= 11'd995 && yaw_us <= 11'd2000
			&& thrust_us >= 11'd1000 && thrust_us <= 11'd1996)
		else $error("yaw/thrust out of range");

endmodule

bind rc_frame_parser_scaler_unit rcfp_checker u_rcfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (rx.ready),
	.out_valid (servo.valid),
	.out_ready (servo.ready),
	.roll_us   (servo.roll_us),
	.pitch_us  (servo.pitch_us),
	.yaw_us    (servo.yaw_us),
	.thrust_us (servo.thrust_us)
);

// File: tb/tb.sv
// Testbench for the RC frame parser and scaler: byte stream in, checked servo commands out.
`timescale 1ns / 1ps
module tb;

	localparam int WatchdogLimit = 2000;
	localparam int SettleCycles  = 8;

	typedef enum logic [1:0] {
		SEEK_START,
		IN_PAYLOAD,
		AT_CHECKSUM,
		AT_END_MARK
	} frame_state_t;

	typedef enum {
		FRAME_OK,
		FRAME_BAD_SUM,
		FRAME_BAD_END,
		FRAME_CUT
	} frame_fault_t;

	typedef struct {
		logic [11:0] roll;
		logic [11:0] pitch;
		logic [10:0] yaw;
		logic [10:0] thrust;
	} servo_cmd_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en = 1'b0;
	logic [rcfp_pkg::CfgIdxW-1:0] cfg_index = rcfp_pkg::CfgStartMarker;
	logic [rcfp_pkg::CfgDataW-1:0] cfg_wdata = '0;

	rcfp_byte_if byte_ch ();
	rcfp_servo_if servo_ch ();

	rc_frame_parser_scaler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(byte_ch),
		.servo(servo_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Parser copy: markers, frame state and payload
	logic [7:0] start_byte = rcfp_pkg::StartMarkerRst;
	logic [7:0] end_byte = rcfp_pkg::EndMarkerRst;
	frame_state_t frame_state = SEEK_START;
	logic [2:0] payload_count = '0;
	logic [7:0] payload_bytes [4];
	logic [7:0] payload_xor = '0;

	logic [7:0] pending_bytes [$];
	servo_cmd_t expected_cmds [$];
	servo_cmd_t oldest_cmd;
	int frame_bytes;
	int gap_pct = 31;
	int stall_pct = 31;
	int mismatches = 0;
	int quiet_cycles = 0;
	bit byte_taken = 1'b0;

	function automatic logic [11:0] scale_stick(input logic [7:0] b);
		int unsigned num;
		num = 64000 + b * 625;
		return 12'(num / 96);
	endfunction

	function automatic logic [10:0] scale_yaw(input logic [7:0] b);
		int unsigned num;
		num = 202100 + b * 800;
		return 11'(num / 203);
	endfunction

	function automatic logic [10:0] scale_thrust(input logic [7:0] b);
		int unsigned num;
		num = b * 256000;
		return 11'(1000 + num / 65535);
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b);
		servo_cmd_t cmd;
		case (frame_state)
			SEEK_START: begin
				if (b == start_byte) begin
					payload_count = '0;
					payload_xor = '0;
					frame_state = IN_PAYLOAD;
				end
			end
			IN_PAYLOAD: begin
				if (payload_count < 3'd4)
					payload_bytes[payload_count[1:0]] = b;
				payload_xor = payload_xor ^ b;
				payload_count = payload_count + 3'd1;
				if (payload_count >= rcfp_pkg::PayloadLen)
					frame_state = AT_CHECKSUM;
			end
			AT_CHECKSUM: begin
				// the byte is never retried as a start marker
				frame_state = (b == payload_xor) ? AT_END_MARK : SEEK_START;
			end
			default: begin
				if (b == end_byte) begin
					cmd.roll = scale_stick(payload_bytes[0]);
					cmd.pitch = scale_stick(payload_bytes[1]);
					cmd.thrust = scale_thrust(payload_bytes[2]);
					cmd.yaw = scale_yaw(payload_bytes[3]);
					expected_cmds.push_back(cmd);
				end
				frame_state = SEEK_START;
			end
		endcase
	endtask

	// Byte driver: hold an offered byte until its transfer
	always @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			parse_rx_byte(byte_ch.rx_byte);
			void'(pending_bytes.pop_front());
			byte_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(byte_ch.valid && !byte_taken)) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
				byte_ch.valid <= 1'b1;
				byte_ch.rx_byte <= pending_bytes[0];
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
		byte_taken = 1'b0;
	end

	// Servo monitor
	always @(negedge clk) begin
		servo_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (servo_ch.valid && servo_ch.ready) begin
			if (expected_cmds.size() == 0) begin
				$error("servo transfer with no frame pending");
				mismatches++;
			end else begin
				oldest_cmd = expected_cmds.pop_front();
				if (servo_ch.roll_us !== oldest_cmd.roll) begin
					$error("roll_us: expected %0d, got %0d", oldest_cmd.roll, servo_ch.roll_us);
					mismatches++;
				end
				if (servo_ch.pitch_us !== oldest_cmd.pitch) begin
					$error("pitch_us: expected %0d, got %0d", oldest_cmd.pitch,
						servo_ch.pitch_us);
					mismatches++;
				end
				if (servo_ch.yaw_us !== oldest_cmd.yaw) begin
					$error("yaw_us: expected %0d, got %0d", oldest_cmd.yaw, servo_ch.yaw_us);
					mismatches++;
				end
				if (servo_ch.thrust_us !== oldest_cmd.thrust) begin
					$error("thrust_us: expected %0d, got %0d", oldest_cmd.thrust,
						servo_ch.thrust_us);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (servo_ch.valid && servo_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_marker(input logic [rcfp_pkg::CfgIdxW-1:0] idx,
			input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == rcfp_pkg::CfgStartMarker)
			start_byte = value;
		else
			end_byte = value;
	endtask

	task automatic queue_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(255));
			// mostly keep noise from opening a frame
			if (b == start_byte && $urandom_range(7) != 0)
				b = ~b;
			pending_bytes.push_back(b);
		end
	endtask

	task automatic queue_frame(input logic [7:0] roll, pitch, thrust, yaw, cmd,
			input frame_fault_t fault, input logic [7:0] bad_byte);
		logic [7:0] body [5];
		logic [7:0] sum;
		int keep;
		body = '{roll, pitch, thrust, yaw, cmd};
		sum = roll ^ pitch ^ thrust ^ yaw ^ cmd;
		keep = (fault == FRAME_CUT) ? int'($urandom_range(4, 1)) : 5;
		pending_bytes.push_back(start_byte);
		for (int i = 0; i < keep; i++)
			pending_bytes.push_back(body[i]);
		frame_bytes += keep + 1;
		if (fault == FRAME_CUT)
			return;
		if (fault == FRAME_BAD_SUM) begin
			pending_bytes.push_back((bad_byte == sum) ? ~sum : bad_byte);
			frame_bytes += 1;
			return;
		end
		pending_bytes.push_back(sum);
		if (fault == FRAME_BAD_END)
			pending_bytes.push_back((bad_byte == end_byte) ? ~end_byte : bad_byte);
		else
			pending_bytes.push_back(end_byte);
		frame_bytes += 2;
	endtask

	function automatic logic [7:0] pick_payload();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(255));
	endfunction

	// Hold the sender until every frame has come out, then let the pipe settle
	task automatic drain();
		while (pending_bytes.size() != 0 || expected_cmds.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic run_phase(input logic [7:0] start_val, end_val, input int byte_goal,
			input int gap, stall);
		int dice;
		frame_fault_t fault;
		write_marker(rcfp_pkg::CfgStartMarker, start_val);
		write_marker(rcfp_pkg::CfgEndMarker, end_val);
		gap_pct = gap;
		stall_pct = stall;
		frame_bytes = 0;
		while (frame_bytes < byte_goal) begin
			if ($urandom_range(3) == 0)
				queue_noise($urandom_range(3, 1));
			dice = $urandom_range(99);
			if (dice < 70)
				fault = FRAME_OK;
			else if (dice < 80)
				fault = FRAME_BAD_SUM;
			else if (dice < 90)
				fault = FRAME_BAD_END;
			else
				fault = FRAME_CUT;
			queue_frame(pick_payload(), pick_payload(), pick_payload(), pick_payload(),
				pick_payload(), fault, 8'($urandom_range(255)));
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.rx_byte = '0;
		servo_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset markers: stray byte, extreme frame, checksum and end
		// failures whose failing byte equals the start marker
		pending_bytes.push_back(8'h00);
		queue_frame(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hA5, FRAME_OK, 8'h00);
		queue_frame(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, FRAME_BAD_SUM,
			rcfp_pkg::StartMarkerRst);
		queue_frame(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h3C, FRAME_BAD_END,
			rcfp_pkg::StartMarkerRst);
		drain();

		run_phase(8'h00, 8'hFF, 120, 0, 0);
		run_phase(8'hFF, 8'h00, 120, 31, 31);
		run_phase(8'h5A, 8'h5A, 120, 31, 31);
		run_phase(rcfp_pkg::EndMarkerRst, rcfp_pkg::StartMarkerRst, 120, 31, 31);
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 120, 31, 31);
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 120, 31, 31);
		run_phase(rcfp_pkg::StartMarkerRst, rcfp_pkg::EndMarkerRst, 120, 31, 31);

		if (expected_cmds.size() != 0) begin
			$error("%0d servo commands never came out", expected_cmds.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
